/* rtl/png_scanline_unfilter_defines.svh */
// ----------------------------------------------------------------------------
// png_scanline_unfilter_defines
// Assertion macros shared by the scanline unfilter modules.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset
`define PSU_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next
`define PSU_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define PSU_ASSERT(name, prop, msg)
`define PSU_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

/* rtl/psu_pkg.sv */
// ----------------------------------------------------------------------------
// psu_pkg
// Types and constants of the PNG scanline unfilter.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

	localparam int DATA_W        = 8;
	localparam int ROW_BYTES_W   = 13;
	localparam int PIXEL_BYTES_W = 4;
	localparam int CFG_IDX_W     = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 1'b1;

	// Highest legal filter type code
	localparam logic [DATA_W-1:0] FILT_MAX_CODE = 8'd4;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filt_t;

	// One request from the row sequencer to the reconstruction stage
	typedef struct packed {
		logic              is_err;
		logic              row_start;
		logic              first_row;
		logic              last;
		filt_t             filt;
		logic [DATA_W-1:0] data;
	} psu_op_t;

endpackage

`default_nettype wire

/* rtl/psu_ram.sv */
// ----------------------------------------------------------------------------
// psu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/psu_ctrl.sv */
// ----------------------------------------------------------------------------
// psu_ctrl
// Row sequencer: configuration, filter type decode, column and halt tracking.
// ----------------------------------------------------------------------------
`default_nettype none
`include "png_scanline_unfilter_defines.svh"

module psu_ctrl #(
	parameter int MAX_ROW_BYTES   = 4096,
	parameter int MAX_PIXEL_BYTES = 8
) (
	input  wire logic                                                 clk,
	input  wire logic                                                 arst_n,
	input  wire logic                                                 cfg_we,
	input  wire logic [psu_pkg::CFG_IDX_W-1:0]                        cfg_index,
	input  wire logic [psu_pkg::ROW_BYTES_W-1:0]                      cfg_data,
	input  wire logic                                                 in_accept,
	input  wire logic [psu_pkg::DATA_W-1:0]                           in_data,
	input  wire logic                                                 in_start,
	output logic                                                      push,
	output psu_pkg::psu_op_t                                          op,
	output logic [((MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1)-1:0]   op_idx,
	output logic [((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)-1:0] pix_sel
);
	import psu_pkg::*;

	localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int COL_W  = $clog2(MAX_ROW_BYTES + 1);
	localparam int CMP_W  = (COL_W > ROW_BYTES_W) ? COL_W : ROW_BYTES_W;
	localparam int PIX_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	logic [COL_W-1:0]         row_len_q;
	logic [PIX_W-1:0]         pix_sel_q;
	logic [COL_W-1:0]         column_q, column_n;
	logic                     first_row_q, first_row_n;
	logic                     halted_q, halted_n;
	filt_t                    filt_q, filt_n;
	logic [CMP_W-1:0]         row_ext;
	logic [CMP_W-1:0]         row_eff;
	logic [PIXEL_BYTES_W-1:0] pix_eff;
	logic [PIXEL_BYTES_W-1:0] pix_eff_m1;
	logic [COL_W-1:0]         idx_ext;
	logic                     col_zero;
	logic                     halt_eff;
	logic                     last;
	logic                     bad_filter;

	// Clamp the written row and pixel lengths to their legal ranges
	always_comb begin
		row_ext = CMP_W'(cfg_data);
		if (row_ext == '0) begin
			row_eff = CMP_W'(1);
		end else if (row_ext > CMP_W'(MAX_ROW_BYTES)) begin
			row_eff = CMP_W'(MAX_ROW_BYTES);
		end else begin
			row_eff = row_ext;
		end
		pix_eff = cfg_data[PIXEL_BYTES_W-1:0];
		if (pix_eff == '0) begin
			pix_eff = PIXEL_BYTES_W'(1);
		end else if (pix_eff > PIXEL_BYTES_W'(MAX_PIXEL_BYTES)) begin
			pix_eff = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
		end
		pix_eff_m1 = pix_eff - PIXEL_BYTES_W'(1);
	end

	// Hold the configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_len_q <= COL_W'(1);
			pix_sel_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_BYTES:   row_len_q <= row_eff[COL_W-1:0];
				REG_PIXEL_BYTES: pix_sel_q <= pix_eff_m1[PIX_W-1:0];
				default:         ;
			endcase
		end
	end

	// Decode where the incoming byte falls in the row
	assign col_zero   = in_start || (column_q == '0);
	assign halt_eff   = !in_start && halted_q;
	assign idx_ext    = column_q - COL_W'(1);
	assign last       = (column_q >= row_len_q);
	assign bad_filter = (in_data > FILT_MAX_CODE);

	// Next row state
	always_comb begin
		column_n    = column_q;
		first_row_n = first_row_q;
		halted_n    = halted_q;
		filt_n      = filt_q;
		if (in_start) begin
			column_n    = '0;
			first_row_n = 1'b1;
			halted_n    = 1'b0;
		end
		if (!halt_eff) begin
			if (col_zero) begin
				if (bad_filter) begin
					halted_n = 1'b1;
				end else begin
					filt_n   = filt_t'(in_data[2:0]);
					column_n = COL_W'(1);
				end
			end else if (last) begin
				column_n    = '0;
				first_row_n = 1'b0;
			end else begin
				column_n = column_q + COL_W'(1);
			end
		end
	end

	// Request to the reconstruction stage
	always_comb begin
		push          = in_accept && !halt_eff && (!col_zero || bad_filter);
		op.is_err     = col_zero;
		op.row_start  = (column_q == COL_W'(1));
		op.first_row  = first_row_q;
		op.last       = last && !col_zero;
		op.filt       = filt_q;
		op.data       = in_data;
		op_idx        = idx_ext[ADDR_W-1:0];
		pix_sel       = pix_sel_q;
	end

	// Advance the row state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			first_row_q <= 1'b1;
			halted_q    <= 1'b0;
			filt_q      <= FILT_NONE;
		end else if (in_accept) begin
			column_q    <= column_n;
			first_row_q <= first_row_n;
			halted_q    <= halted_n;
			filt_q      <= filt_n;
		end
	end

	`PSU_ASSERT_NEXT(a_err_halts, push && op.is_err, halted_q, "error request did not halt")
	`PSU_ASSERT(a_col_bound, column_q <= COL_W'(MAX_ROW_BYTES), "column beyond row store")
	`PSU_ASSERT(a_start_no_data, (in_accept && in_start) |-> !(push && !op.is_err), "image start taken as sample")

endmodule

`default_nettype wire

/* rtl/psu_recon.sv */
// ----------------------------------------------------------------------------
// psu_recon
// Reconstruction stage: predictor, neighbor history and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "png_scanline_unfilter_defines.svh"

module psu_recon #(
	parameter int MAX_ROW_BYTES   = 4096,
	parameter int MAX_PIXEL_BYTES = 8
) (
	input  wire logic                                                      clk,
	input  wire logic                                                      arst_n,
	input  wire logic                                                      push,
	input  wire psu_pkg::psu_op_t                                          op,
	input  wire logic [((MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1)-1:0]   op_idx,
	input  wire logic [((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)-1:0] pix_sel,
	output logic                                                           ready,
	output logic [((MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1)-1:0]        ram_raddr,
	output logic                                                           ram_we,
	output logic [((MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1)-1:0]        ram_waddr,
	output logic [psu_pkg::DATA_W-1:0]                                     ram_wdata,
	input  wire logic [psu_pkg::DATA_W-1:0]                                ram_rdata,
	output logic                                                           m_axis_tvalid,
	input  wire logic                                                      m_axis_tready,
	output logic [psu_pkg::DATA_W-1:0]                                     m_axis_tdata,
	output logic                                                           m_axis_tlast,
	output logic                                                           m_axis_tuser
);
	import psu_pkg::*;

	localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

	// Predictor for one filter type, all modulo 256
	function automatic logic [DATA_W-1:0] predict(
		filt_t f, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b, logic [DATA_W-1:0] c
	);
		logic [DATA_W-1:0] pa;
		logic [DATA_W-1:0] pb;
		logic [DATA_W:0]   pc;
		logic [DATA_W:0]   ab;
		logic [DATA_W:0]   c2;
		logic [DATA_W-1:0] res;
		pa = (b > c) ? (b - c) : (c - b);
		pb = (a > c) ? (a - c) : (c - a);
		ab = {1'b0, a} + {1'b0, b};
		c2 = {c, 1'b0};
		pc = (ab > c2) ? (ab - c2) : (c2 - ab);
		unique case (f)
			FILT_NONE: res = '0;
			FILT_SUB:  res = a;
			FILT_UP:   res = b;
			FILT_AVG:  res = ab[DATA_W:1];
			FILT_PAETH: begin
				if ((pa <= pb) && ({1'b0, pa} <= pc)) begin
					res = a;
				end else if ({1'b0, pb} <= pc) begin
					res = b;
				end else begin
					res = c;
				end
			end
			default:   res = '0;
		endcase
		return res;
	endfunction

	logic              valid_s1;
	psu_op_t           op_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic              s1_fire;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_last_q;
	logic              out_err_q;
	logic [DATA_W-1:0] left_q [MAX_PIXEL_BYTES];
	logic [DATA_W-1:0] upl_q  [MAX_PIXEL_BYTES];
	logic [DATA_W-1:0] nb_a;
	logic [DATA_W-1:0] nb_b;
	logic [DATA_W-1:0] nb_c;
	logic [DATA_W-1:0] val;

	// Stage handshake: the output register parts stage 1 from the sink
	assign s1_fire = valid_s1 && (!out_valid_q || m_axis_tready);
	assign ready   = !valid_s1 || s1_fire;

	// Re-read the held entry while stage 1 stalls
	assign ram_raddr = (valid_s1 && !s1_fire) ? idx_s1 : op_idx;

	// Neighbors and reconstructed byte
	always_comb begin
		nb_a = op_s1.row_start ? '0 : left_q[pix_sel];
		nb_c = op_s1.row_start ? '0 : upl_q[pix_sel];
		nb_b = op_s1.first_row ? '0 : ram_rdata;
		val  = op_s1.data + predict(op_s1.filt, nb_a, nb_b, nb_c);
	end

	// Write the reconstructed byte back as next row's upper neighbor
	assign ram_we    = s1_fire && !op_s1.is_err;
	assign ram_waddr = idx_s1;
	assign ram_wdata = val;

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (push) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (push) begin
			op_s1  <= op;
			idx_s1 <= op_idx;
		end
	end

	// Shift the left and upper-left history, dropping it at row start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
				left_q[k] <= '0;
				upl_q[k]  <= '0;
			end
		end else if (ram_we) begin
			left_q[0] <= val;
			upl_q[0]  <= nb_b;
			for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
				left_q[k] <= op_s1.row_start ? '0 : left_q[k-1];
				upl_q[k]  <= op_s1.row_start ? '0 : upl_q[k-1];
			end
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_data_q <= op_s1.is_err ? '0 : val;
			out_last_q <= op_s1.last;
			out_err_q  <= op_s1.is_err;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_err_q;

	`PSU_ASSERT(a_err_fields, (m_axis_tvalid && m_axis_tuser) |-> (!m_axis_tlast && m_axis_tdata == '0), "error result carries data")
	`PSU_ASSERT_NEXT(a_hold_idx, valid_s1 && !s1_fire, valid_s1 && $stable(idx_s1), "stalled entry lost")
	`PSU_ASSERT_NEXT(a_fire_loads, s1_fire, out_valid_q, "result not registered")

endmodule

`default_nettype wire

/* rtl/png_scanline_unfilter.sv */
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG filter method 0 reconstruction over an inflated byte stream.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and gives one reconstructed byte per cycle,
// sustained while m_axis_tready does not stall the output. As a sample byte
// enters stage 1 the byte above is read from the previous-row RAM (one
// entry per column); stage 1 runs the None/Sub/Up/Average/Paeth predictor,
// writes the result back to the same entry and loads the output register.
// Legal filter type bytes and bytes dropped after an error give no result;
// an illegal one gives an error result. The row RAM is not cleared after
// reset: on the first row of an image the row above reads as zero, so no
// clearing pass is needed and the block accepts input right out of reset.
`default_nettype none

module png_scanline_unfilter #(
	parameter int MAX_ROW_BYTES   = 4096,
	parameter int MAX_PIXEL_BYTES = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [psu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [psu_pkg::ROW_BYTES_W-1:0]    cfg_data,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [psu_pkg::DATA_W-1:0]         s_axis_tdata,  // [7:0] data_byte
	input  wire logic                               s_axis_tuser,  // [0] image_start
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic [psu_pkg::DATA_W-1:0]              m_axis_tdata,  // [7:0] pixel_byte
	output logic                                    m_axis_tlast,  // last_in_row
	output logic                                    m_axis_tuser   // [0] status
);
	import psu_pkg::*;

	localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int PIX_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	logic              in_accept;
	logic              push;
	psu_op_t           op;
	logic [ADDR_W-1:0] op_idx;
	logic [PIX_W-1:0]  pix_sel;
	logic [ADDR_W-1:0] ram_raddr;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;

	assign in_accept = s_axis_tvalid && s_axis_tready;

	// Row sequencer
	psu_ctrl #(
		.MAX_ROW_BYTES   (MAX_ROW_BYTES),
		.MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_accept (in_accept),
		.in_data   (s_axis_tdata),
		.in_start  (s_axis_tuser),
		.push      (push),
		.op        (op),
		.op_idx    (op_idx),
		.pix_sel   (pix_sel)
	);

	// Previous row store
	psu_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_ROW_BYTES)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Reconstruction and output
	psu_recon #(
		.MAX_ROW_BYTES   (MAX_ROW_BYTES),
		.MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
	) u_recon (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.op            (op),
		.op_idx        (op_idx),
		.pix_sel       (pix_sel),
		.ready         (s_axis_tready),
		.ram_raddr     (ram_raddr),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_rdata     (ram_rdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire
